>>> rtl/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
// No dependencies; imported by stq_out and sorted_timer_queue.
`default_nettype none

package stq_pkg;

	localparam int OP_W      = 2;
	localparam int ID_W      = 4;
	localparam int DELAY_W   = 24;
	localparam int CFG_W     = 16;
	localparam int KIND_W    = 2;
	localparam int LEFT_W    = 32;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 40;
	localparam int M_PAD_W   = M_TDATA_W - (ID_W + 1 + LEFT_W + 1);
	localparam int MAX_FIRES = 16;
	localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

	localparam logic [CFG_W-1:0] TPU_RESET = 16'd100;

	localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
	localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD,
		KIND_DEL,
		KIND_FIRED,
		KIND_IDLE
	} kind_t;

	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] id;
		logic            act;
		logic            empty;
		logic            last;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/sorted_timer_queue.sv
// Sorted timer queue top level: prescaled time base, ordered list and deadline memories.
// Depends on stq_pkg and stq_out.
//
// channel   dir  handshake                    contents
// cfg       in   cfg_valid / cfg_ready        ticks_per_unit
// s_axis    in   s_axis_tvalid / tready       tuser opcode; tdata timer_id, delay
// m_axis    out  m_axis_tvalid / tready       tuser kind; tdata result; tlast last result
//
// A tick advances the time base and fires due timers one at a time; a delete walks the list once.
// An add that replaces an armed timer walks the order memory twice: unlink, then link.
// Reset needs no clearing pass; input is taken only in idle.
// A stalled output holds the walk at its next result; config is taken at any time.
`default_nettype none

module sorted_timer_queue import stq_pkg::*; #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data,       // ticks_per_unit
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,   // timer_id, delay
	input  logic [OP_W-1:0]      s_axis_tuser,   // opcode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,   // fired_id, was_active, time_left, queue_empty
	output logic [KIND_W-1:0]    m_axis_tuser,   // kind
	output logic                 m_axis_tlast
);

	localparam int SW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_UNLINK,
		S_LINK_INIT,
		S_LINK,
		S_INSERT,
		S_REF1,
		S_REF2,
		S_REF3,
		S_EMIT_OP,
		S_FIRE_CHK,
		S_FIRE_EMIT
	} state_t;

	function automatic logic [SW-1:0] ring_addr(input logic [SW-1:0] base,
		input logic [SW-1:0] pos);
		logic [SW:0] sum;
		sum = {1'b0, base} + {1'b0, pos};
		if (sum >= (SW+1)'(NUM_TIMERS)) begin
			sum = sum - (SW+1)'(NUM_TIMERS);
		end
		return sum[SW-1:0];
	endfunction

	state_t                state_q;
	logic [CFG_W-1:0]      tpu_q;
	logic [CFG_W-1:0]      prescale_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [CW-1:0]         count_q;
	logic [NUM_TIMERS-1:0] active_q;
	logic [SW-1:0]         head_ptr_q;
	logic [SW-1:0]         head_id_q;
	logic [TIME_BITS-1:0]  head_dl_q;
	logic [OP_W-1:0]       op_q;
	logic [ID_W-1:0]       id_q;
	logic [SW-1:0]         slot_q;
	logic                  act_q;
	logic [TIME_BITS-1:0]  dl_new_q;
	logic [SW-1:0]         iss_pos_q;
	logic [CW-1:0]         iss_left_q;
	logic                  found_q;
	logic [SW-1:0]         ins_pos_q;
	logic [FIRE_W-1:0]     fires_q;
	logic [SW-1:0]         fired_q;
	logic                  v_s1;
	logic [SW-1:0]         pos_s1;
	logic                  v_s2;
	logic [SW-1:0]         pos_s2;
	logic [SW-1:0]         id_s2;

	logic [SW-1:0]         order_mem [NUM_TIMERS];
	logic [TIME_BITS-1:0]  dl_mem [NUM_TIMERS];
	logic [SW-1:0]         order_rd_q;
	logic [TIME_BITS-1:0]  dl_rd_q;

	logic                  accept;
	logic [OP_W-1:0]       s_op;
	logic [ID_W-1:0]       s_id;
	logic [DELAY_W-1:0]    s_delay;
	logic [SW-1:0]         s_slot;
	logic                  id_ok;
	logic [CFG_W-1:0]      p_inc;
	logic                  cond_fire;
	logic                  out_free;
	logic                  load;
	res_t                  res;
	logic                  order_we;
	logic [SW-1:0]         order_waddr;
	logic [SW-1:0]         order_wdata;
	logic [SW-1:0]         order_raddr;
	logic                  dl_we;
	logic [TIME_BITS-1:0]  dl_wdata;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_op          = s_axis_tuser;
	assign s_id          = s_axis_tdata[ID_W-1:0];
	assign s_delay       = s_axis_tdata[ID_W +: DELAY_W];
	assign s_slot        = SW'(s_id);
	assign id_ok         = int'(s_id) < NUM_TIMERS;
	assign p_inc         = prescale_q + CFG_W'(1);
	assign cond_fire     = (count_q != '0) && (head_dl_q <= now_q)
		&& (fires_q < FIRE_W'(MAX_FIRES));

	assign dl_we    = accept && (s_op == OP_ADD) && id_ok;
	assign dl_wdata = now_q + TIME_BITS'(s_delay);

	assign order_raddr = (state_q == S_REF1) ? head_ptr_q : ring_addr(head_ptr_q, iss_pos_q);

	always_comb begin
		order_we    = 1'b0;
		order_waddr = ring_addr(head_ptr_q, ins_pos_q);
		order_wdata = slot_q;
		unique case (state_q)
			S_UNLINK: begin
				order_we    = v_s1 && found_q && (order_rd_q != slot_q);
				order_waddr = ring_addr(head_ptr_q, pos_s1 - SW'(1));
				order_wdata = order_rd_q;
			end
			S_LINK: begin
				order_we    = v_s2 && (dl_rd_q > dl_new_q);
				order_waddr = ring_addr(head_ptr_q, pos_s2 + SW'(1));
				order_wdata = id_s2;
			end
			S_INSERT: begin
				order_we = 1'b1;
			end
			default: begin
				order_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (order_we) begin
			order_mem[order_waddr] <= order_wdata;
		end
		order_rd_q <= order_mem[order_raddr];
	end

	always_ff @(posedge clk) begin
		if (dl_we) begin
			dl_mem[s_slot] <= dl_wdata;
		end
		dl_rd_q <= dl_mem[order_rd_q];
	end

	always_comb begin
		load       = 1'b0;
		res.kind   = KIND_ADD;
		res.id     = id_q;
		res.act    = 1'b0;
		res.empty  = (count_q == '0);
		res.last   = 1'b1;
		unique case (state_q)
			S_EMIT_OP: begin
				load     = out_free;
				res.kind = (op_q == OP_DEL) ? KIND_DEL : KIND_ADD;
				res.act  = act_q;
			end
			S_FIRE_CHK: begin
				load     = out_free && !cond_fire;
				res.kind = KIND_IDLE;
				res.id   = '0;
			end
			S_FIRE_EMIT: begin
				load     = out_free;
				res.kind = KIND_FIRED;
				res.id   = ID_W'(fired_q);
				res.last = !cond_fire;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tpu_q      <= TPU_RESET;
			prescale_q <= '0;
			now_q      <= '0;
			count_q    <= '0;
			active_q   <= '0;
			head_ptr_q <= '0;
			head_id_q  <= '0;
			head_dl_q  <= '0;
			op_q       <= OP_ADD;
			id_q       <= '0;
			slot_q     <= '0;
			act_q      <= 1'b0;
			dl_new_q   <= '0;
			iss_pos_q  <= '0;
			iss_left_q <= '0;
			found_q    <= 1'b0;
			ins_pos_q  <= '0;
			fires_q    <= '0;
			fired_q    <= '0;
			v_s1       <= 1'b0;
			pos_s1     <= '0;
			v_s2       <= 1'b0;
			pos_s2     <= '0;
			id_s2      <= '0;
		end else begin
			if (cfg_valid) begin
				tpu_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= s_op;
						id_q       <= s_id;
						slot_q     <= s_slot;
						dl_new_q   <= dl_wdata;
						act_q      <= 1'b0;
						found_q    <= 1'b0;
						iss_pos_q  <= '0;
						iss_left_q <= count_q;
						v_s1       <= 1'b0;
						v_s2       <= 1'b0;
						fires_q    <= '0;
						unique case (s_op)
							OP_ADD: begin
								if (!id_ok) begin
									state_q <= S_EMIT_OP;
								end else if (active_q[s_slot]) begin
									state_q <= S_UNLINK;
								end else begin
									state_q <= S_LINK_INIT;
								end
							end
							OP_DEL: begin
								if (id_ok && active_q[s_slot]) begin
									act_q   <= 1'b1;
									state_q <= S_UNLINK;
								end else begin
									state_q <= S_EMIT_OP;
								end
							end
							OP_TICK: begin
								if (p_inc >= tpu_q) begin
									prescale_q <= '0;
									now_q      <= now_q + TIME_BITS'(1);
								end else begin
									prescale_q <= p_inc;
								end
								state_q <= S_FIRE_CHK;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_UNLINK: begin
					if (iss_left_q != '0) begin
						v_s1       <= 1'b1;
						pos_s1     <= iss_pos_q;
						iss_pos_q  <= iss_pos_q + SW'(1);
						iss_left_q <= iss_left_q - CW'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1) begin
						if (order_rd_q == slot_q) begin
							found_q <= 1'b1;
						end
						if (CW'(pos_s1) == count_q - CW'(1)) begin
							count_q          <= count_q - CW'(1);
							active_q[slot_q] <= 1'b0;
							state_q          <= (op_q == OP_ADD) ? S_LINK_INIT : S_REF1;
						end
					end
				end
				S_LINK_INIT: begin
					iss_pos_q  <= SW'(count_q - CW'(1));
					iss_left_q <= count_q;
					v_s1       <= 1'b0;
					v_s2       <= 1'b0;
					if (count_q == '0) begin
						ins_pos_q <= '0;
						state_q   <= S_INSERT;
					end else begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					if (iss_left_q != '0) begin
						v_s1       <= 1'b1;
						pos_s1     <= iss_pos_q;
						iss_pos_q  <= iss_pos_q - SW'(1);
						iss_left_q <= iss_left_q - CW'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					v_s2   <= v_s1;
					pos_s2 <= pos_s1;
					id_s2  <= order_rd_q;
					if (v_s2) begin
						if (dl_rd_q > dl_new_q) begin
							if (pos_s2 == '0) begin
								ins_pos_q <= '0;
								state_q   <= S_INSERT;
							end
						end else begin
							ins_pos_q <= pos_s2 + SW'(1);
							state_q   <= S_INSERT;
						end
					end
				end
				S_INSERT: begin
					count_q          <= count_q + CW'(1);
					active_q[slot_q] <= 1'b1;
					state_q          <= S_REF1;
				end
				S_REF1: begin
					if (count_q == '0) begin
						state_q <= (op_q == OP_TICK) ? S_FIRE_EMIT : S_EMIT_OP;
					end else begin
						state_q <= S_REF2;
					end
				end
				S_REF2: begin
					head_id_q <= order_rd_q;
					state_q   <= S_REF3;
				end
				S_REF3: begin
					head_dl_q <= dl_rd_q;
					state_q   <= (op_q == OP_TICK) ? S_FIRE_EMIT : S_EMIT_OP;
				end
				S_EMIT_OP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FIRE_CHK: begin
					if (cond_fire) begin
						active_q[head_id_q] <= 1'b0;
						head_ptr_q          <= ring_addr(head_ptr_q, SW'(1));
						count_q             <= count_q - CW'(1);
						fired_q             <= head_id_q;
						fires_q             <= fires_q + FIRE_W'(1);
						state_q             <= S_REF1;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FIRE_EMIT: begin
					if (out_free) begin
						if (cond_fire) begin
							active_q[head_id_q] <= 1'b0;
							head_ptr_q          <= ring_addr(head_ptr_q, SW'(1));
							count_q             <= count_q - CW'(1);
							fired_q             <= head_id_q;
							fires_q             <= fires_q + FIRE_W'(1);
							state_q             <= S_REF1;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	stq_out #(
		.TIME_BITS(TIME_BITS)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.res          (res),
		.head_dl      (head_dl_q),
		.now_units    (now_q),
		.free         (out_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NUM_TIMERS))
		else $error("queued count beyond slot count");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> $countones(active_q) == int'(count_q))
		else $error("queued count disagrees with active slots");

	a_head_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && count_q != '0) |-> active_q[head_id_q])
		else $error("cached head is not an active slot");

	a_fired_gone: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIRE_EMIT |-> !active_q[fired_q])
		else $error("fired timer still active");
`endif

endmodule

`default_nettype wire

>>> rtl/stq_out.sv
// Result register of the sorted timer queue: works out the time left and holds one result.
// Depends on stq_pkg.
`default_nettype none

module stq_out import stq_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  res_t                 res,
	input  logic [TIME_BITS-1:0] head_dl,
	input  logic [TIME_BITS-1:0] now_units,
	output logic                 free,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // fired_id, was_active, time_left, queue_empty
	output logic [KIND_W-1:0]    m_axis_tuser,  // kind
	output logic                 m_axis_tlast
);

	logic [TIME_BITS-1:0] diff;
	logic [LEFT_W-1:0]    left;
	logic                 tvalid_q;
	logic [M_TDATA_W-1:0] tdata_q;
	logic [KIND_W-1:0]    tuser_q;
	logic                 tlast_q;

	assign diff = head_dl - now_units;

	always_comb begin
		if (res.empty || !(head_dl > now_units)) begin
			left = '0;
		end else if (TIME_BITS > LEFT_W && (diff >> LEFT_W) != '0) begin
			left = '1;
		end else begin
			left = LEFT_W'(diff);
		end
	end

	assign free = !tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (load) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tdata_q <= {M_PAD_W'(0), res.empty, left, res.act, res.id};
			tuser_q <= res.kind;
			tlast_q <= res.last;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;
	assign m_axis_tlast  = tlast_q;

endmodule

`default_nettype wire

>>> tb/tb_sorted_timer_queue.sv
// Self-checking bench for sorted_timer_queue: directed and random add, delete and tick requests.
// A scoreboard class tracks the timer list and checks every output; depends on stq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sorted_timer_queue;
	import stq_pkg::*;

	localparam int SLOTS  = 16;
	localparam int SETTLE = 64;

	typedef struct {
		kind_t             kind;
		logic [ID_W-1:0]   id;
		logic              act;
		logic [LEFT_W-1:0] left;
		logic              empty;
		logic              last;
	} timer_result_t;

	class deadline_tracker;
		logic [LEFT_W-1:0] due_at[SLOTS];
		logic [ID_W-1:0]   order[SLOTS];
		bit                armed[SLOTS];
		int                queued;
		logic [LEFT_W-1:0] now_units;
		logic [CFG_W-1:0]  prescale;
		logic [CFG_W-1:0]  ticks_per_unit;
		timer_result_t     pending_results[$];
		int                errors;

		function new();
			queued         = 0;
			now_units      = '0;
			prescale       = '0;
			ticks_per_unit = TPU_RESET;
			errors         = 0;
			foreach (armed[i]) armed[i] = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("%0t: %s", $time, msg);
		endtask

		function void unlink(int id);
			int i;
			for (i = 0; i < queued; i++) begin
				if (order[i] == id) begin
					for (int j = i; j + 1 < queued; j++) order[j] = order[j + 1];
					queued--;
					break;
				end
			end
			armed[id] = 0;
		endfunction

		function void link(int id);
			int pos;
			pos = 0;
			while (pos < queued && due_at[order[pos]] <= due_at[id]) pos++;
			for (int j = queued; j > pos; j--) order[j] = order[j - 1];
			order[pos] = ID_W'(id);
			queued++;
			armed[id] = 1;
		endfunction

		function void queue_result(kind_t kind, int id, bit act, bit last);
			timer_result_t r;
			r.kind  = kind;
			r.id    = ID_W'(id);
			r.act   = act;
			r.left  = '0;
			if (queued > 0 && due_at[order[0]] > now_units) r.left = due_at[order[0]] - now_units;
			r.empty = (queued == 0);
			r.last  = last;
			pending_results.push_back(r);
		endfunction

		function void take_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
				logic [DELAY_W-1:0] dly);
			int            fired;
			int            f;
			timer_result_t r;
			fired = 0;
			case (op)
				OP_ADD: begin
					if (armed[id]) unlink(id);
					due_at[id] = now_units + dly;
					link(id);
					queue_result(KIND_ADD, id, 0, 1);
				end
				OP_DEL: begin
					if (armed[id]) begin
						unlink(id);
						queue_result(KIND_DEL, id, 1, 1);
					end else begin
						queue_result(KIND_DEL, id, 0, 1);
					end
				end
				OP_TICK: begin
					prescale = prescale + 1'b1;
					if (prescale >= ticks_per_unit) begin
						prescale  = '0;
						now_units = now_units + 1'b1;
					end
					while (queued > 0 && fired < MAX_FIRES && due_at[order[0]] <= now_units) begin
						f = order[0];
						unlink(f);
						queue_result(KIND_FIRED, f, 0, 0);
						fired++;
					end
					if (fired == 0) begin
						queue_result(KIND_IDLE, 0, 0, 1);
					end else begin
						r = pending_results[$];
						void'(pending_results.pop_back());
						r.last = 1'b1;
						pending_results.push_back(r);
					end
				end
				default: ;
			endcase
		endfunction

		task check_result(kind_t kind, logic [M_TDATA_W-1:0] d, logic last);
			timer_result_t e;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result kind %0d id %0d", kind, d[ID_W-1:0]));
				return;
			end
			e = pending_results.pop_front();
			if (kind !== e.kind || d[3:0] !== e.id || d[4] !== e.act || d[36:5] !== e.left
					|| d[37] !== e.empty || last !== e.last)
				report($sformatf({"result mismatch (got/exp): kind %0d/%0d id %0d/%0d ",
					"act %0d/%0d left %0d/%0d empty %0d/%0d last %0d/%0d"},
					kind, e.kind, d[3:0], e.id, d[4], e.act, d[36:5], e.left,
					d[37], e.empty, last, e.last));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [OP_W-1:0]      s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [KIND_W-1:0]    m_axis_tuser;
	logic                 m_axis_tlast;

	logic rx_hold = 1'b0;
	logic calm = 1'b0;
	int   rx_stall = 0;
	int   n_requests = 0;
	event hold_off;

	deadline_tracker tracker;

	sorted_timer_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// output side: check, then pick next tready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(kind_t'(m_axis_tuser), m_axis_tdata, m_axis_tlast);
		if (rx_hold) begin
			m_axis_tready <= 1'b0;
		end else if (calm) begin
			m_axis_tready <= 1'b1;
		end else if (rx_stall > 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_stall = $urandom_range(1, 11) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// long receiver hold-off so the block backs up
	initial forever begin
		@(hold_off);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
			logic [DELAY_W-1:0] dly);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {{(S_TDATA_W - DELAY_W - ID_W){1'b0}}, dly, id};
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_request(op, id, dly);
		if (op != OP_NOP) n_requests++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic drain(bit settle);
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_results.size() != 0) @(posedge clk);
		if (settle) repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_tpu(logic [CFG_W-1:0] value);
		drain(1);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.ticks_per_unit = value;
	endtask

	function automatic logic [DELAY_W-1:0] rand_delay();
		case ($urandom_range(0, 9))
			0:       return '1;
			1, 2:    return DELAY_W'($urandom);
			default: return DELAY_W'($urandom_range(0, 12));
		endcase
	endfunction

	task automatic random_phase(int quota, int pause_at, bit squeeze);
		int slot_pick[SLOTS];
		int k;
		int t;
		int r;
		int target;
		target = n_requests + quota;
		if (squeeze) -> hold_off;
		while (n_requests < target) begin
			if (pause_at > 0 && n_requests == target - quota + pause_at) drain(0);
			if ($urandom_range(0, 3) == 0) begin
				// fill a run of distinct slots, then send a run of ticks
				foreach (slot_pick[i]) slot_pick[i] = i;
				for (int i = SLOTS - 1; i > 0; i--) begin
					r = $urandom_range(0, i);
					t = slot_pick[i];
					slot_pick[i] = slot_pick[r];
					slot_pick[r] = t;
				end
				k = ($urandom_range(0, 2) == 0) ? SLOTS : $urandom_range(2, SLOTS - 1);
				for (int i = 0; i < k; i++)
					send_request(OP_ADD, ID_W'(slot_pick[i]), DELAY_W'($urandom_range(0, 3)));
				repeat ($urandom_range(2, 12)) send_request(OP_TICK, ID_W'($urandom), rand_delay());
			end else begin
				r = $urandom_range(0, 19);
				if (r == 0)
					send_request(OP_NOP, ID_W'($urandom), DELAY_W'($urandom));
				else if (r < 8)
					send_request(OP_ADD, ID_W'($urandom), rand_delay());
				else if (r < 12)
					send_request(OP_DEL, ID_W'($urandom), rand_delay());
				else
					send_request(OP_TICK, ID_W'($urandom), rand_delay());
			end
		end
	endtask

	initial begin
		tracker       = new();
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		arst_n        = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, widest delay, equal deadlines, deletes, re-add
		send_request(OP_TICK, 4'd0, 24'd0);
		send_request(OP_ADD, 4'd0, 24'hFFFFFF);
		send_request(OP_ADD, 4'd15, 24'd0);
		send_request(OP_ADD, 4'd7, 24'd0);
		send_request(OP_TICK, 4'd0, 24'd0);
		send_request(OP_DEL, 4'd0, 24'd0);
		send_request(OP_DEL, 4'd0, 24'd0);
		send_request(OP_NOP, 4'd15, 24'hFFFFFF);
		send_request(OP_ADD, 4'd3, 24'd5);
		send_request(OP_ADD, 4'd9, 24'd3);
		send_request(OP_ADD, 4'd3, 24'd2);
		repeat (3) send_request(OP_TICK, 4'd0, 24'd0);
		// prescaler already past the new divider
		write_tpu(16'd2);
		repeat (5) send_request(OP_TICK, 4'd0, 24'd0);
		send_request(OP_DEL, 4'd12, 24'd0);
		send_request(OP_DEL, 4'd9, 24'd0);

		write_tpu(16'd1);
		random_phase(42, 0, 0);
		write_tpu(16'hFFFF);
		random_phase(42, 20, 0);
		write_tpu(16'd3);
		random_phase(42, 0, 1);
		write_tpu(CFG_W'($urandom_range(1, 6)));
		random_phase(42, 0, 0);
		write_tpu(16'd1);
		calm <= 1'b1;
		random_phase(40, 0, 0);

		drain(1);
		if (tracker.errors == 0 && tracker.pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/stq_pkg.sv
rtl/stq_out.sv
rtl/sorted_timer_queue.sv
tb/tb_sorted_timer_queue.sv
